>>> design/circular_deque_assert.svh
// Assertion macros for the circular deque.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge out of reset
`define CDQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("circular_deque: assertion failed");

// Check that a condition never occurs
`define CDQ_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("circular_deque: forbidden condition seen");

`else

`define CDQ_ASSERT(lbl, prop)
`define CDQ_NEVER(lbl, cond)

`endif

`endif

>>> design/cdq_pkg.sv
package cdq_pkg;

	localparam int DEPTH = 8;
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Operation codes of an input transaction
	typedef enum logic [1:0] {
		KIND_PUSH_REAR  = 2'd0,
		KIND_PUSH_FRONT = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Broadcast control to every cell of the chain
	typedef struct packed {
		logic take_prev;  // shift toward the rear, cell 0 takes the pushed word
		logic take_next;  // shift toward the front
		logic fill_end;   // first free cell takes the pushed word
		logic drop_end;   // last occupied cell empties
	} cell_ctrl_t;

endpackage

>>> design/circular_deque.sv
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------
// input   | in_valid / in_ready  | kind, push_value
// output  | out_valid / out_ready| pop_value, status
//
// One transaction per cycle while in_ready is high; its result appears in the cycle after acceptance.
// The queue lives in a row of DEPTH cells, front word in cell 0; a push or pop
// at the front shifts every cell by one in that cycle, rear operations touch
// only the cell at the end of the occupied run.
// in_ready drops only while a result is held and out_ready is low.
// Reset leaves the queue empty with no result pending.
`include "circular_deque_assert.svh"

module circular_deque (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     kind,
	input  cdq_pkg::word_t push_value,
	output logic           out_valid,
	input  logic           out_ready,
	output cdq_pkg::word_t pop_value,
	output logic [1:0]     status
);
	import cdq_pkg::*;

	logic [DEPTH-1:0] valid_vec;
	logic [DEPTH-1:0] last_vec;
	logic [DEPTH-1:0] prev_valid_vec;
	logic [DEPTH-1:0] next_valid_vec;
	word_t            data_arr      [DEPTH];
	word_t            prev_data_arr [DEPTH];
	word_t            next_data_arr [DEPTH];

	cell_ctrl_t ctrl;
	logic       in_fire;
	logic       is_push;
	logic       full;
	logic       empty;
	word_t      rear_data;

	logic       out_valid_q;
	word_t      pop_value_q;
	status_t    status_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_push  = (kind == KIND_PUSH_REAR) || (kind == KIND_PUSH_FRONT);
	assign full     = valid_vec[DEPTH-1];
	assign empty    = !valid_vec[0];

	// Decode the transaction into cell control
	always_comb begin
		ctrl.take_prev = in_fire && (kind == KIND_PUSH_FRONT) && !full;
		ctrl.take_next = in_fire && (kind == KIND_POP_FRONT) && !empty;
		ctrl.fill_end  = in_fire && (kind == KIND_PUSH_REAR) && !full;
		ctrl.drop_end  = in_fire && (kind == KIND_POP_REAR) && !empty;
	end

	// Wire neighbors; cell 0 sees the pushed word in front of it
	always_comb begin
		prev_valid_vec[0] = 1'b1;
		prev_data_arr[0]  = push_value;
		for (int i = 1; i < DEPTH; i++) begin
			prev_valid_vec[i] = valid_vec[i-1];
			prev_data_arr[i]  = data_arr[i-1];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			next_valid_vec[i] = valid_vec[i+1];
			next_data_arr[i]  = data_arr[i+1];
		end
		next_valid_vec[DEPTH-1] = 1'b0;
		next_data_arr[DEPTH-1]  = '0;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_value (push_value),
			.prev_valid (prev_valid_vec[g]),
			.prev_data  (prev_data_arr[g]),
			.next_valid (next_valid_vec[g]),
			.next_data  (next_data_arr[g]),
			.valid      (valid_vec[g]),
			.data       (data_arr[g]),
			.is_last    (last_vec[g])
		);
	end

	// Select the rear word by the single end-of-run flag
	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | (last_vec[i] ? data_arr[i] : word_t'(0));
		end
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (is_push) begin
				pop_value_q <= '0;
				status_q    <= full ? ST_OVERFLOW : ST_DONE;
			end else if (empty) begin
				pop_value_q <= '0;
				status_q    <= ST_UNDERFLOW;
			end else begin
				pop_value_q <= (kind == KIND_POP_FRONT) ? data_arr[0] : rear_data;
				status_q    <= ST_DONE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

	// Occupied cells form one run starting at cell 0
	`CDQ_ASSERT(a_occ_prefix, ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
	`CDQ_ASSERT(a_one_rear, $onehot0(last_vec) && ($countones(last_vec) == {31'd0, !empty}))
	`CDQ_ASSERT(a_overflow, (in_fire && is_push && full) |=> (status_q == ST_OVERFLOW))
	`CDQ_ASSERT(a_underflow, in_fire && !is_push && empty |=> status_q == ST_UNDERFLOW)
	`CDQ_NEVER(a_push_lost, in_fire && is_push && !full && $countones(valid_vec) == DEPTH)

endmodule

>>> design/cdq_cell.sv
module cdq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cdq_pkg::cell_ctrl_t ctrl,
	input  cdq_pkg::word_t    push_value,
	input  logic              prev_valid,
	input  cdq_pkg::word_t    prev_data,
	input  logic              next_valid,
	input  cdq_pkg::word_t    next_data,
	output logic              valid,
	output cdq_pkg::word_t    data,
	output logic              is_last
);
	import cdq_pkg::*;

	logic  valid_q;
	word_t data_q;

	// Track occupancy of this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.take_prev) begin
			valid_q <= prev_valid;
		end else if (ctrl.take_next) begin
			valid_q <= next_valid;
		end else if (ctrl.fill_end && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end else if (ctrl.drop_end && valid_q && !next_valid) begin
			valid_q <= 1'b0;
		end
	end

	// Move the stored word along with its neighbors
	always_ff @(posedge clk) begin
		if (ctrl.take_prev) begin
			data_q <= prev_data;
		end else if (ctrl.take_next) begin
			data_q <= next_data;
		end else if (ctrl.fill_end && !valid_q && prev_valid) begin
			data_q <= push_value;
		end
	end

	assign valid   = valid_q;
	assign data    = data_q;
	assign is_last = valid_q && !next_valid;

endmodule

>>> verif/tb_circular_deque.sv
`timescale 1ns / 100ps

module tb_circular_deque;
	import cdq_pkg::*;

	localparam int NUM_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 438;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS = 10;

	// One pending transaction, or a hold-off marker that waits for all results
	typedef struct {
		kind_t kind;
		word_t value;
		int    idle_pct;
		int    stall_pct;
		bit    hold_off;
	} pend_item_t;

	typedef struct {
		word_t   pop_value;
		status_t status;
	} deque_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = KIND_PUSH_REAR;
	word_t      push_value = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	word_t      pop_value;
	logic [1:0] status;

	pend_item_t    stim_q[$];
	deque_result_t owed_results[$];
	bit            results_owed = 1'b0;
	int            stall_pct = 0;
	int            error_count = 0;
	int            quiet_cycles = 0;

	// Predictor state
	word_t       dq_slot [DEPTH];
	int unsigned dq_head = 0;
	int unsigned dq_tail = 0;
	bit          dq_empty = 1'b1;

	circular_deque dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pop_value  (pop_value),
		.status     (status)
	);

	always #1 clk = ~clk;

	// Apply one operation to the predicted deque and return its result
	function automatic deque_result_t deque_apply(kind_t op, word_t v);
		deque_result_t r;
		r.pop_value = '0;
		r.status = ST_DONE;
		if (op == KIND_PUSH_REAR || op == KIND_PUSH_FRONT) begin
			if (dq_empty) begin
				dq_head = 0;
				dq_tail = 0;
				dq_slot[0] = v;
				dq_empty = 1'b0;
			end else if ((dq_tail + 1) % DEPTH == dq_head) begin
				r.status = ST_OVERFLOW;
			end else if (op == KIND_PUSH_REAR) begin
				dq_tail = (dq_tail + 1) % DEPTH;
				dq_slot[dq_tail] = v;
			end else begin
				dq_head = (dq_head + DEPTH - 1) % DEPTH;
				dq_slot[dq_head] = v;
			end
		end else if (dq_empty) begin
			r.status = ST_UNDERFLOW;
		end else begin
			r.pop_value = (op == KIND_POP_FRONT) ? dq_slot[dq_head] : dq_slot[dq_tail];
			if (dq_head == dq_tail) begin
				dq_empty = 1'b1;
				dq_head = 0;
				dq_tail = 0;
			end else if (op == KIND_POP_FRONT) begin
				dq_head = (dq_head + 1) % DEPTH;
			end else begin
				dq_tail = (dq_tail + DEPTH - 1) % DEPTH;
			end
		end
		return r;
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_op(kind_t op, word_t v, int idle, int stall);
		pend_item_t it;
		it.kind = op;
		it.value = v;
		it.idle_pct = idle;
		it.stall_pct = stall;
		it.hold_off = 1'b0;
		stim_q.push_back(it);
	endtask

	task automatic queue_hold_off();
		pend_item_t it;
		it.kind = KIND_PUSH_REAR;
		it.value = '0;
		it.idle_pct = 0;
		it.stall_pct = 0;
		it.hold_off = 1'b1;
		stim_q.push_back(it);
	endtask

	task automatic flag_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Drive the input channel; hold the payload until the transaction is taken
	always @(posedge clk or negedge arst_n) begin : drv
		pend_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_PUSH_REAR;
			push_value <= '0;
		end else if (!in_valid || in_ready) begin
			if (stim_q.size() != 0 && stim_q[0].hold_off) begin
				if (!in_valid && !results_owed)
					void'(stim_q.pop_front());
				in_valid <= 1'b0;
			end else if (stim_q.size() != 0 && $urandom_range(99) >= stim_q[0].idle_pct) begin
				nxt = stim_q.pop_front();
				kind <= nxt.kind;
				push_value <= nxt.value;
				stall_pct <= nxt.stall_pct;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Predict on each input transaction, check each result transaction
	always @(posedge clk) begin : mon
		deque_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				owed_results.push_back(deque_apply(kind_t'(kind), push_value));
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result: pop_value=%0d status=%0d",
						pop_value, status));
				end else begin
					want = owed_results.pop_front();
					if (pop_value !== want.pop_value)
						flag_mismatch($sformatf("pop_value mismatch: expected %0d, got %0d",
							want.pop_value, pop_value));
					if (status !== want.status)
						flag_mismatch($sformatf("status mismatch: expected %0d, got %0d",
							want.status, status));
				end
			end
			results_owed <= (owed_results.size() != 0);
		end
	end

	// Stop the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int send_idle [NUM_PHASES];
		int recv_stall [NUM_PHASES];
		int made;
		int run;
		int push_bias;
		kind_t op;

		send_idle = '{0, 57, 0, 17};
		recv_stall = '{0, 0, 57, 17};
		foreach (dq_slot[i])
			dq_slot[i] = '0;

		// Directed: empty pops, push-front on empty, last-word pop, fill to full,
		// overflow at both ends, drain from both ends, pop after drain
		queue_op(KIND_POP_FRONT, pick_word(), 0, 0);
		queue_op(KIND_POP_REAR, pick_word(), 0, 0);
		queue_op(KIND_PUSH_FRONT, 32'h7fff_ffff, 0, 0);
		queue_op(KIND_POP_REAR, pick_word(), 0, 0);
		queue_op(KIND_PUSH_REAR, 32'h8000_0000, 0, 0);
		queue_op(KIND_PUSH_FRONT, 32'hffff_ffff, 0, 0);
		queue_op(KIND_PUSH_REAR, 32'h0000_0000, 0, 0);
		queue_op(KIND_PUSH_FRONT, 32'h5555_5555, 0, 0);
		queue_op(KIND_PUSH_REAR, 32'haaaa_aaaa, 0, 0);
		queue_op(KIND_PUSH_FRONT, 32'h0000_0001, 0, 0);
		queue_op(KIND_PUSH_REAR, 32'h7fff_ffff, 0, 0);
		queue_op(KIND_PUSH_FRONT, 32'h8000_0000, 0, 0);
		queue_op(KIND_PUSH_REAR, 32'h1234_5678, 0, 0);
		queue_op(KIND_PUSH_FRONT, 32'hfedc_ba98, 0, 0);
		for (int i = 0; i < 7; i++) begin
			if (i % 2 != 0)
				queue_op(KIND_POP_REAR, pick_word(), 0, 0);
			else
				queue_op(KIND_POP_FRONT, pick_word(), 0, 0);
		end
		queue_op(KIND_POP_FRONT, pick_word(), 0, 0);
		queue_op(KIND_POP_REAR, pick_word(), 0, 0);
		queue_hold_off();

		// Random: bursts that lean toward filling, draining or neither
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			made = 0;
			while (made < ITEMS_PER_PHASE) begin
				run = $urandom_range(24, 4);
				case ($urandom_range(2))
					0: push_bias = 80;
					1: push_bias = 20;
					default: push_bias = 50;
				endcase
				for (int j = 0; j < run; j++) begin
					if ($urandom_range(99) < push_bias) begin
						if ($urandom_range(1) != 0)
							op = KIND_PUSH_FRONT;
						else
							op = KIND_PUSH_REAR;
					end else begin
						if ($urandom_range(1) != 0)
							op = KIND_POP_FRONT;
						else
							op = KIND_POP_REAR;
					end
					queue_op(op, pick_word(), send_idle[ph], recv_stall[ph]);
				end
				made += run;
			end
			queue_hold_off();
		end

		// Release reset away from the clock edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all transactions and results, then let the pipeline settle
		while (stim_q.size() != 0) @(posedge clk);
		@(posedge clk);
		while (in_valid || results_owed) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (owed_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", owed_results.size()));

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/cdq_pkg.sv
design/cdq_cell.sv
design/circular_deque.sv
verif/tb_circular_deque.sv
